/* rtl/core/chinese_numeral_to_decimal_macros.svh */
// assertion macros for the chinese numeral converter, used by cnl_ctrl
// expects clk and rst in scope at the point of use
`ifndef CHINESE_NUMERAL_TO_DECIMAL_MACROS_SVH
`define CHINESE_NUMERAL_TO_DECIMAL_MACROS_SVH

// same-cycle implication
`define CNL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CNL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cnl_pkg.sv */
// shared types, symbol codes and the utf-8 symbol decoder
// no dependencies
`default_nettype none

package cnl_pkg;

  localparam int SYM_COUNT = 16;

  // internal symbol values: digits 0..9, then the units
  localparam logic [3:0] SYM_ZERO   = 4'd0;
  localparam logic [3:0] SYM_ONE    = 4'd1;
  localparam logic [3:0] SYM_NINE   = 4'd9;
  localparam logic [3:0] SYM_TEN    = 4'd10;
  localparam logic [3:0] SYM_MYRIAD = 4'd13;

  localparam logic [23:0] SYM_CODE [SYM_COUNT] = '{
    24'hE99BB6, 24'hE4B880, 24'hE4BA8C, 24'hE4B889, 24'hE59B9B, 24'hE4BA94,
    24'hE585AD, 24'hE4B883, 24'hE585AB, 24'hE4B99D, 24'hE58D81, 24'hE799BE,
    24'hE58D83, 24'hE4B887, 24'hE585A9, 24'hE890AC
  };

  localparam logic [3:0] SYM_VALUE [SYM_COUNT] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
    4'd10, 4'd11, 4'd12, 4'd13, 4'd2, 4'd13
  };

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } sym_t;

  // one result toward the output register
  typedef struct packed {
    logic       valid;
    logic [3:0] digit;
    logic       eon;
  } push_t;

  function automatic sym_t decode_symbol(input logic [23:0] code);
    sym_t r;
    r = '{ok: 1'b0, value: SYM_ZERO};
    for (int i = 0; i < SYM_COUNT; i++) begin
      if (code == SYM_CODE[i]) begin
        r.ok    = 1'b1;
        r.value = SYM_VALUE[i];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cnl_alu.sv */
// shared 4-bit subtractor with borrow, used for unit compares,
// zero counts and the zero-run countdown; no dependencies
`default_nettype none

module cnl_alu (
  input  wire logic [3:0] a,
  input  wire logic [3:0] b,
  output logic      [3:0] diff,
  output logic            borrow
);

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

`default_nettype wire

/* rtl/core/cnl_outbuf.sv */
// single result register between the sequencer and the output channel
// depends on cnl_pkg
`default_nettype none

module cnl_outbuf import cnl_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire push_t      push,
  output logic            push_rdy,
  output logic      [5:0] digit_char,
  output logic            end_of_number,
  output logic            digit_valid,
  input  wire logic       digit_ready
);

  logic [3:0] digit;
  logic       eon;

  assign push_rdy      = !digit_valid || digit_ready;
  assign digit_char    = {2'b11, digit};
  assign end_of_number = eon;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_valid <= 1'b0;
    end else if (push.valid) begin
      digit_valid <= 1'b1;
    end else if (digit_ready) begin
      digit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      digit <= push.digit;
      eon   <= push.eon;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cnl_ctrl.sv */
// sequencer and numeral state: decode, take, zero runs and end of number
// depends on cnl_pkg, cnl_alu and the assertion macro header
`default_nettype none
`include "chinese_numeral_to_decimal_macros.svh"

module cnl_ctrl import cnl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        char_valid,
  input  wire logic [23:0] char_code,
  input  wire logic        is_last,
  output logic             char_ready,
  output push_t            push,
  input  wire logic        push_rdy
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HELD = 3'd1;
  localparam logic [2:0] ST_MAIN = 3'd2;
  localparam logic [2:0] ST_TAKE = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam logic [2:0] ST_LAST = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] ret_state, ret_state_next;
  logic [3:0] sym, sym_next;
  logic       sym_ok, sym_ok_next;
  logic       last_flag, last_flag_next;
  logic [3:0] take_sym, take_sym_next;
  logic       first_take, first_take_next;
  logic [2:0] cnt, cnt_next;
  logic       tail, tail_next;
  logic [3:0] tail_d, tail_d_next;
  logic       held_valid, held_valid_next;
  logic [3:0] pu, pu_next;
  logic [3:0] pd, pd_next;
  logic       at_first, at_first_next;
  logic       stopped, stopped_next;
  logic       any_emitted, any_emitted_next;
  logic [3:0] last_out, last_out_next;

  sym_t       dec;
  logic [3:0] alu_a, alu_b, alu_diff;
  logic       alu_borrow;
  logic       emit_ok, do_emit;
  logic [3:0] emit_d;

  assign dec     = decode_symbol(char_code);
  assign emit_ok = !any_emitted || push_rdy;

  cnl_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  // operand selection for the shared subtractor
  always_comb begin
    alu_a = pu;
    alu_b = SYM_TEN;
    case (state)
      ST_TAKE: begin
        if (take_sym < SYM_TEN) begin
          alu_a = SYM_TEN;
          alu_b = pu;
        end else if (take_sym == SYM_MYRIAD) begin
          alu_b = SYM_NINE;
        end else begin
          alu_b = 4'(take_sym + 4'd1);
        end
      end
      ST_EMIT: begin
        alu_a = {1'b0, cnt};
        alu_b = 4'd1;
      end
      default: begin
        alu_a = pu;
        alu_b = SYM_TEN;
      end
    endcase
  end

  always_comb begin
    state_next       = state;
    ret_state_next   = ret_state;
    sym_next         = sym;
    sym_ok_next      = sym_ok;
    last_flag_next   = last_flag;
    take_sym_next    = take_sym;
    first_take_next  = first_take;
    cnt_next         = cnt;
    tail_next        = tail;
    tail_d_next      = tail_d;
    held_valid_next  = held_valid;
    pu_next          = pu;
    pd_next          = pd;
    at_first_next    = at_first;
    stopped_next     = stopped;
    any_emitted_next = any_emitted;
    last_out_next    = last_out;
    push             = '0;
    do_emit          = 1'b0;
    emit_d           = SYM_ZERO;
    char_ready       = (state == ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (char_valid) begin
          sym_next       = dec.value;
          sym_ok_next    = dec.ok;
          last_flag_next = is_last;
          state_next     = ST_HELD;
        end
      end
      ST_HELD: begin
        if (stopped) begin
          state_next = last_flag ? ST_LAST : ST_IDLE;
        end else if (!sym_ok) begin
          stopped_next = 1'b1;
          if (held_valid) begin
            held_valid_next = 1'b0;
            at_first_next   = 1'b0;
          end
          state_next = last_flag ? ST_LAST : ST_IDLE;
        end else if (held_valid) begin
          held_valid_next = 1'b0;
          if (sym == SYM_TEN) begin
            // zero before ten counts as one
            take_sym_next   = SYM_ONE;
            first_take_next = 1'b1;
            state_next      = ST_TAKE;
          end else begin
            at_first_next = 1'b0;
            state_next    = ST_MAIN;
          end
        end else begin
          state_next = ST_MAIN;
        end
      end
      ST_MAIN: begin
        if (sym == SYM_ZERO) begin
          held_valid_next = 1'b1;
          state_next      = last_flag ? ST_LAST : ST_IDLE;
        end else begin
          take_sym_next   = sym;
          first_take_next = 1'b0;
          state_next      = ST_TAKE;
        end
      end
      ST_TAKE: begin
        ret_state_next = first_take ? ST_MAIN : (last_flag ? ST_LAST : ST_IDLE);
        cnt_next       = '0;
        tail_next      = 1'b0;
        tail_d_next    = pd;
        at_first_next  = 1'b0;
        state_next     = ST_EMIT;
        if (at_first && take_sym == SYM_TEN) begin
          tail_next   = 1'b1;
          tail_d_next = SYM_ONE;
          pu_next     = SYM_TEN;
          pd_next     = SYM_ZERO;
        end else if (take_sym < SYM_TEN) begin
          // digit: write now unless a unit above ten is in force
          if (!alu_borrow) begin
            tail_next   = 1'b1;
            tail_d_next = take_sym;
            pu_next     = SYM_ZERO;
          end else begin
            pd_next = take_sym;
          end
        end else if (take_sym < SYM_MYRIAD) begin
          if (!alu_borrow) begin
            cnt_next = 3'(alu_diff);
          end
          tail_next   = (pu != SYM_ZERO);
          tail_d_next = pd;
          pu_next     = take_sym;
          pd_next     = SYM_ZERO;
        end else begin
          if (!alu_borrow) begin
            cnt_next = 3'(alu_diff);
          end
          pu_next = SYM_MYRIAD;
          pd_next = SYM_ZERO;
        end
      end
      ST_EMIT: begin
        if (cnt != '0) begin
          if (emit_ok) begin
            do_emit  = 1'b1;
            emit_d   = SYM_ZERO;
            cnt_next = 3'(alu_diff);
          end
        end else if (tail) begin
          if (emit_ok) begin
            do_emit   = 1'b1;
            emit_d    = tail_d;
            tail_next = 1'b0;
          end
        end else begin
          state_next = ret_state;
        end
      end
      ST_LAST: begin
        cnt_next       = '0;
        tail_next      = 1'b0;
        tail_d_next    = pd;
        held_valid_next = 1'b0;
        if (!alu_borrow) begin
          cnt_next  = 3'(alu_diff);
          tail_next = 1'b1;
        end
        ret_state_next = ST_FIN;
        state_next     = ST_EMIT;
      end
      ST_FIN: begin
        if (push_rdy) begin
          push.valid       = 1'b1;
          push.digit       = any_emitted ? last_out : SYM_ZERO;
          push.eon         = 1'b1;
          held_valid_next  = 1'b0;
          pu_next          = SYM_ZERO;
          pd_next          = SYM_ZERO;
          at_first_next    = 1'b1;
          stopped_next     = 1'b0;
          any_emitted_next = 1'b0;
          last_out_next    = SYM_ZERO;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // the digit written before is released, the new one is held back
    if (do_emit) begin
      push.valid       = any_emitted;
      push.digit       = last_out;
      push.eon         = 1'b0;
      last_out_next    = emit_d;
      any_emitted_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      ret_state   <= ST_IDLE;
      sym         <= SYM_ZERO;
      sym_ok      <= 1'b0;
      last_flag   <= 1'b0;
      take_sym    <= SYM_ZERO;
      first_take  <= 1'b0;
      cnt         <= '0;
      tail        <= 1'b0;
      tail_d      <= SYM_ZERO;
      held_valid  <= 1'b0;
      pu          <= SYM_ZERO;
      pd          <= SYM_ZERO;
      at_first    <= 1'b1;
      stopped     <= 1'b0;
      any_emitted <= 1'b0;
      last_out    <= SYM_ZERO;
    end else begin
      state       <= state_next;
      ret_state   <= ret_state_next;
      sym         <= sym_next;
      sym_ok      <= sym_ok_next;
      last_flag   <= last_flag_next;
      take_sym    <= take_sym_next;
      first_take  <= first_take_next;
      cnt         <= cnt_next;
      tail        <= tail_next;
      tail_d      <= tail_d_next;
      held_valid  <= held_valid_next;
      pu          <= pu_next;
      pd          <= pd_next;
      at_first    <= at_first_next;
      stopped     <= stopped_next;
      any_emitted <= any_emitted_next;
      last_out    <= last_out_next;
    end
  end

  `CNL_ASSERT_NOW(a_push_fits, push.valid, push_rdy, "push while output register is full")
  `CNL_ASSERT_NOW(a_unit_legal, 1'b1, (pu == SYM_ZERO) || (pu >= SYM_TEN), "bad unit in force")
  `CNL_ASSERT_NOW(a_eon_in_fin, push.valid && push.eon, state == ST_FIN, "end of number outside final step")
  `CNL_ASSERT_NEXT(a_fin_clears, push.valid && push.eon, (state == ST_IDLE) && at_first && !any_emitted && (pu == SYM_ZERO), "state not cleared after number end")

endmodule

`default_nettype wire

/* rtl/core/chinese_numeral_to_decimal.sv */
// top level of the chinese numeral to ascii decimal converter
// depends on cnl_pkg, cnl_ctrl (with cnl_alu) and cnl_outbuf
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------
//   char     | char_valid / char_ready   | char_code[23:0], is_last
//   digit    | digit_valid / digit_ready | digit_char[5:0], end_of_number
//
// one request at a time: char_ready is high only while the sequencer idles;
// an unrecognised or ignored character only passes the decode step, a zero
// is held for lookahead, and a digit or unit is taken and then emitted, one
// emit step per digit written; a last character adds a final step plus one
// per deferred zero and kept digit, all around one shared 4-bit subtractor
// rst is synchronous: the number state goes back to empty, no digit pending
// a stalled digit channel holds the sequencer only at the steps that write
`default_nettype none

module chinese_numeral_to_decimal import cnl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        char_valid,
  output logic             char_ready,
  input  wire logic [23:0] char_code,
  input  wire logic        is_last,
  output logic             digit_valid,
  input  wire logic        digit_ready,
  output logic      [5:0]  digit_char,
  output logic             end_of_number
);

  // one result per cycle at most from the sequencer into the output register, only while it has room
  push_t push;
  logic  push_rdy;

  // sequencer: symbol decode, zero lookahead, deferred zeros and the
  // held-back last digit that carries the end-of-number mark
  cnl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_code  (char_code),
    .is_last    (is_last),
    .char_ready (char_ready),
    .push       (push),
    .push_rdy   (push_rdy)
  );

  // output register: a finished digit waits here while the sequencer
  // moves on with the next step
  cnl_outbuf u_outbuf (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .push_rdy      (push_rdy),
    .digit_char    (digit_char),
    .end_of_number (end_of_number),
    .digit_valid   (digit_valid),
    .digit_ready   (digit_ready)
  );

endmodule

`default_nettype wire

/* verif/cnl_digit_predictor.sv */
// predicts the digits of each chinese numeral and checks the digit channel
// watches both channels of chinese_numeral_to_decimal; needs nothing else
module cnl_digit_predictor (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  input  logic        char_ready,
  input  logic [23:0] char_code,
  input  logic        is_last,
  input  logic        digit_valid,
  input  logic        digit_ready,
  input  logic [5:0]  digit_char,
  input  logic        end_of_number,
  output int          mismatches,
  output int          outstanding
);

  localparam logic [23:0] CODE_ZERO       = 24'hE99BB6;
  localparam logic [23:0] CODE_ONE        = 24'hE4B880;
  localparam logic [23:0] CODE_TWO        = 24'hE4BA8C;
  localparam logic [23:0] CODE_THREE      = 24'hE4B889;
  localparam logic [23:0] CODE_FOUR       = 24'hE59B9B;
  localparam logic [23:0] CODE_FIVE       = 24'hE4BA94;
  localparam logic [23:0] CODE_SIX        = 24'hE585AD;
  localparam logic [23:0] CODE_SEVEN      = 24'hE4B883;
  localparam logic [23:0] CODE_EIGHT      = 24'hE585AB;
  localparam logic [23:0] CODE_NINE       = 24'hE4B99D;
  localparam logic [23:0] CODE_TEN        = 24'hE58D81;
  localparam logic [23:0] CODE_HUNDRED    = 24'hE799BE;
  localparam logic [23:0] CODE_THOUSAND   = 24'hE58D83;
  localparam logic [23:0] CODE_MYRIAD     = 24'hE4B887;
  localparam logic [23:0] CODE_TWO_ALT    = 24'hE585A9;
  localparam logic [23:0] CODE_MYRIAD_ALT = 24'hE890AC;

  localparam int UNIT_TEN      = 10;
  localparam int UNIT_HUNDRED  = 11;
  localparam int UNIT_THOUSAND = 12;
  localparam int UNIT_MYRIAD   = 13;
  localparam int NOT_A_SYMBOL  = -1;
  localparam logic [5:0] ASCII_ZERO = 6'h30;

  typedef struct packed {
    logic [5:0] ascii;
    logic       eon;
  } digit_t;

  digit_t expected_digits [$];
  digit_t want;
  int     errors = 0;

  // number state
  logic       zero_waiting;
  logic [3:0] unit_in_force;
  logic [3:0] kept_digit;
  logic       number_fresh;
  logic       number_halted;
  logic       digit_held;
  logic [3:0] held_digit;

  assign mismatches = errors;

  function automatic int symbol_value(input logic [23:0] code);
    case (code)
      CODE_ZERO:                    return 0;
      CODE_ONE:                     return 1;
      CODE_TWO, CODE_TWO_ALT:       return 2;
      CODE_THREE:                   return 3;
      CODE_FOUR:                    return 4;
      CODE_FIVE:                    return 5;
      CODE_SIX:                     return 6;
      CODE_SEVEN:                   return 7;
      CODE_EIGHT:                   return 8;
      CODE_NINE:                    return 9;
      CODE_TEN:                     return UNIT_TEN;
      CODE_HUNDRED:                 return UNIT_HUNDRED;
      CODE_THOUSAND:                return UNIT_THOUSAND;
      CODE_MYRIAD, CODE_MYRIAD_ALT: return UNIT_MYRIAD;
      default:                      return NOT_A_SYMBOL;
    endcase
  endfunction

  task automatic clear_number();
    zero_waiting  = 1'b0;
    unit_in_force = '0;
    kept_digit    = '0;
    number_fresh  = 1'b1;
    number_halted = 1'b0;
    digit_held    = 1'b0;
    held_digit    = '0;
  endtask

  task automatic push_digit(input logic [3:0] d, input logic eon);
    digit_t e;
    e.ascii = ASCII_ZERO + 6'(d);
    e.eon   = eon;
    expected_digits.push_back(e);
  endtask

  // the newest digit stays back so that the end of the number can be marked on it
  task automatic write_digit(input logic [3:0] d);
    if (digit_held)
      push_digit(held_digit, 1'b0);
    held_digit = d;
    digit_held = 1'b1;
  endtask

  task automatic write_zeros(input int n);
    for (int i = 0; i < n; i++)
      write_digit('0);
  endtask

  task automatic apply_symbol(input int s);
    if (number_fresh && s == UNIT_TEN) begin
      write_digit(4'd1);
      unit_in_force = 4'(UNIT_TEN);
      kept_digit    = '0;
    end else if (s < UNIT_TEN) begin
      if (unit_in_force <= UNIT_TEN) begin
        write_digit(4'(s));
        unit_in_force = '0;
      end else begin
        kept_digit = 4'(s);
      end
    end else if (s < UNIT_MYRIAD) begin
      if (unit_in_force > s + 1)
        write_zeros(unit_in_force - s - 1);
      if (unit_in_force != 0)
        write_digit(kept_digit);
      unit_in_force = 4'(s);
      kept_digit    = '0;
    end else begin
      if (unit_in_force >= UNIT_TEN)
        write_zeros(unit_in_force - (UNIT_TEN - 1));
      unit_in_force = 4'(UNIT_MYRIAD);
      kept_digit    = '0;
    end
    number_fresh = 1'b0;
  endtask

  task automatic predict_request(input logic [23:0] code, input logic last);
    int s;
    if (!number_halted) begin
      s = symbol_value(code);
      if (s == NOT_A_SYMBOL) begin
        if (zero_waiting) begin
          zero_waiting = 1'b0;
          number_fresh = 1'b0;
        end
        number_halted = 1'b1;
      end else begin
        // a held zero counts as one only in front of ten
        if (zero_waiting) begin
          zero_waiting = 1'b0;
          if (s == UNIT_TEN)
            apply_symbol(1);
          else
            number_fresh = 1'b0;
        end
        if (s == 0)
          zero_waiting = 1'b1;
        else
          apply_symbol(s);
      end
    end
    if (last) begin
      if (unit_in_force >= UNIT_TEN) begin
        write_zeros(unit_in_force - UNIT_TEN);
        write_digit(kept_digit);
      end
      if (digit_held)
        push_digit(held_digit, 1'b1);
      else
        push_digit('0, 1'b1);
      clear_number();
    end
  endtask

  task automatic report(input string field, input int exp_val, input int got_val);
    errors++;
    $error("%s: expected %0d, got %0d", field, exp_val, got_val);
  endtask

  initial clear_number();

  always @(posedge clk) begin
    if (rst) begin
      clear_number();
      expected_digits.delete();
    end else begin
      if (char_valid && char_ready)
        predict_request(char_code, is_last);
      if (digit_valid && digit_ready) begin
        if (expected_digits.size() == 0) begin
          report("digit_char (none expected)", -1, digit_char);
        end else begin
          want = expected_digits.pop_front();
          if (digit_char !== want.ascii)
            report("digit_char", want.ascii, digit_char);
          if (end_of_number !== want.eon)
            report("end_of_number", want.eon, end_of_number);
        end
      end
    end
    outstanding <= expected_digits.size();
  end

endmodule

/* verif/chinese_numeral_to_decimal_test.sv */
// top of the chinese numeral converter testbench: clock, reset, requests, verdict
// depends on cnl_pkg for the symbol codes and on cnl_digit_predictor for checking
module chinese_numeral_to_decimal_test;

  // cycle budget; the slowest legal run is far below this
  localparam int RUN_LIMIT     = 200000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 280;
  localparam int IDLE_PCT      = 10;

  // indexes into the package symbol table; digits sit at their own value
  localparam int ZERO_IDX       = 0;
  localparam int TEN_IDX        = 10;
  localparam int HUNDRED_IDX    = 11;
  localparam int THOUSAND_IDX   = 12;
  localparam int MYRIAD_IDX     = 13;
  localparam int TWO_ALT_IDX    = 14;
  localparam int MYRIAD_ALT_IDX = 15;

  // string phases where the pressure patterns kick in
  localparam int HOLD_STRING        = 10;
  localparam int HOLD_STRING_END    = 16;
  localparam int PAUSE_STRING       = 30;
  localparam int NO_IDLE_STRING     = 40;
  localparam int NO_IDLE_STRING_END = 55;
  localparam int NO_PAUSE           = -1;

  localparam int PLACE [4] = '{1, 10, 100, 1000};

  typedef logic [23:0] code_q_t [$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_ready;
  logic [23:0] char_code = '0;
  logic        is_last = 1'b0;
  logic        digit_valid;
  logic        digit_ready = 1'b0;
  logic [5:0]  digit_char;
  logic        end_of_number;

  int   mismatches;
  int   outstanding;
  int   cycle_count;
  int   items_counted = 0;
  int   sender_idle_pct = IDLE_PCT;
  int   recv_idle_pct = IDLE_PCT;
  // each flip asks the receiver process for one long hold-off
  logic hold_toggle = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  chinese_numeral_to_decimal dut (.*);

  // predicts and compares on its own; hands back the error tally and the
  // number of digits still owed by the block
  cnl_digit_predictor predictor (.*);

  function automatic logic [23:0] sym(input int idx);
    return cnl_pkg::SYM_CODE[idx];
  endfunction

  function automatic bit is_symbol(input logic [23:0] code);
    bit found;
    found = 1'b0;
    for (int i = 0; i < cnl_pkg::SYM_COUNT; i++)
      if (cnl_pkg::SYM_CODE[i] == code)
        found = 1'b1;
    return found;
  endfunction

  // random 24-bit code that is no numeral symbol
  function automatic logic [23:0] junk_code();
    logic [23:0] c;
    do
      c = 24'($urandom);
    while (is_symbol(c));
    return c;
  endfunction

  // either plain junk or a symbol with one bit flipped
  function automatic logic [23:0] broken_code();
    if ($urandom_range(1))
      return junk_code();
    return sym($urandom_range(cnl_pkg::SYM_COUNT - 1)) ^ (24'd1 << $urandom_range(23));
  endfunction

  // one four-digit group in the usual written form, e.g. three thousand zero five
  task automatic add_group(ref code_q_t q, input int grp, input bit zero_first,
                           input bit at_head);
    int d;
    bit zero_due;
    bit started;
    zero_due = zero_first;
    started  = 1'b0;
    for (int p = 3; p >= 0; p--) begin
      d = (grp / PLACE[p]) % 10;
      if (d == 0) begin
        if (started)
          zero_due = 1'b1;
      end else begin
        if (zero_due)
          q.push_back(sym(ZERO_IDX));
        zero_due = 1'b0;
        // a leading one in front of ten is often left out
        if (!(p == 1 && d == 1 && at_head && !started && $urandom_range(1)))
          q.push_back(sym((d == 2 && $urandom_range(1)) ? TWO_ALT_IDX : d));
        if (p > 0)
          q.push_back(sym(p == 3 ? THOUSAND_IDX : p == 2 ? HUNDRED_IDX : TEN_IDX));
        started = 1'b1;
      end
    end
  endtask

  // well-formed number; mostly short, sometimes up to eight digits
  task automatic add_number(ref code_q_t q);
    int value;
    int hi;
    int lo;
    case ($urandom_range(3))
      0:       value = $urandom_range(9);
      1:       value = $urandom_range(99);
      2:       value = $urandom_range(9999);
      default: value = $urandom_range(99999999);
    endcase
    hi = value / 10000;
    lo = value % 10000;
    if (value == 0)
      q.push_back(sym(ZERO_IDX));
    if (hi != 0) begin
      add_group(q, hi, 1'b0, 1'b1);
      q.push_back(sym($urandom_range(1) ? MYRIAD_ALT_IDX : MYRIAD_IDX));
    end
    if (lo != 0)
      add_group(q, lo, hi != 0 && lo < 1000, hi == 0);
  endtask

  // one character request; valid drops only when an idle gap is taken
  task automatic send_char(input logic [23:0] code, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct)
      gap++;
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code  <= code;
    is_last    <= last;
    @(posedge clk);
    while (!char_ready)
      @(posedge clk);
  endtask

  // sender stands still until the block owes no more digits
  task automatic wait_drained();
    char_valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
  endtask

  // a whole string, is_last on its final character; characters after an
  // unrecognised one are still sent and counted, the block ignores them
  task automatic send_codes(input code_q_t codes, input int pause_at);
    foreach (codes[k]) begin
      if (k == pause_at)
        wait_drained();
      send_char(codes[k], k == codes.size() - 1);
      items_counted++;
    end
  endtask

  // receiver: random stalls, plus a long hold-off counted here on request
  initial begin : receiver
    int   hold_left;
    logic seen_toggle;
    hold_left   = 0;
    seen_toggle = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        digit_ready <= 1'b0;
      end else begin
        digit_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("chinese_numeral_to_decimal: mismatch");
    $finish;
  end

  initial begin : stimulus
    code_q_t codes;
    int      choice;
    int      strings;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty number: nothing but junk gives a lone zero digit
    codes = {junk_code()};
    send_codes(codes, NO_PAUSE);
    codes = {24'hFFFFFF};
    send_codes(codes, NO_PAUSE);
    // junk first, then a digit that must be ignored
    codes = {24'h000000, sym(3)};
    send_codes(codes, NO_PAUSE);
    // ten alone as first symbol
    codes = {sym(TEN_IDX)};
    send_codes(codes, NO_PAUSE);
    // lone zero is dropped, still gives zero
    codes = {sym(ZERO_IDX)};
    send_codes(codes, NO_PAUSE);
    // zero in front of ten reads as one
    codes = {sym(ZERO_IDX), sym(TEN_IDX), sym(5)};
    send_codes(codes, NO_PAUSE);
    // every unit in one number
    codes = {sym(9), sym(MYRIAD_IDX), sym(8), sym(THOUSAND_IDX), sym(6),
             sym(HUNDRED_IDX), sym(4), sym(TEN_IDX), sym(7)};
    send_codes(codes, NO_PAUSE);
    // synonyms and a repeated ten-thousand
    codes = {sym(TWO_ALT_IDX), sym(MYRIAD_ALT_IDX), sym(MYRIAD_IDX)};
    send_codes(codes, NO_PAUSE);
    // junk in the middle ends the number
    codes = {sym(1), junk_code(), sym(5)};
    send_codes(codes, NO_PAUSE);

    strings = 0;
    while (items_counted < RANDOM_ITEMS) begin
      codes = {};
      // long receiver hold while the sender keeps pushing without gaps
      if (strings == HOLD_STRING) begin
        hold_toggle <= ~hold_toggle;
        sender_idle_pct = 0;
      end
      if (strings == HOLD_STRING_END)
        sender_idle_pct = IDLE_PCT;
      // stretch with no idling on either side
      if (strings == NO_IDLE_STRING) begin
        sender_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      if (strings == NO_IDLE_STRING_END) begin
        sender_idle_pct = IDLE_PCT;
        recv_idle_pct <= IDLE_PCT;
      end

      choice = $urandom_range(99);
      if (choice < 55) begin
        add_number(codes);
      end else if (choice < 75) begin
        // any mix of symbols, including odd unit orders
        repeat ($urandom_range(8, 1))
          codes.push_back(sym($urandom_range(cnl_pkg::SYM_COUNT - 1)));
      end else if (choice < 90) begin
        // well-formed number broken by a bad character somewhere
        add_number(codes);
        codes.insert($urandom_range(codes.size()), broken_code());
      end else begin
        // raw noise over the full code range
        repeat ($urandom_range(4, 1))
          codes.push_back(24'($urandom));
      end
      send_codes(codes, strings == PAUSE_STRING ? codes.size() / 2 : NO_PAUSE);
      strings++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("chinese_numeral_to_decimal: match");
    else
      $display("chinese_numeral_to_decimal: mismatch");
    $finish;
  end

endmodule
